// ===== hw/rtl/mstb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstb_pkg
// Shared constants and types for the maximum spanning tree bottleneck block.
// ----------------------------------------------------------------------------
package mstb_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int AW           = 2 * VW;
  localparam int CW           = 7;

  localparam logic signed [31:0] WEIGHT_FLOOR = -32'sd2147483646;

  localparam logic [1:0] ST_FOUND        = 2'd0;
  localparam logic [1:0] ST_DISCONNECTED = 2'd1;
  localparam logic [1:0] ST_SINGLE       = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;        // store the accepted word into the matrix
    logic pass_a;      // first half of a store pair (a,b), else (b,a)
    logic init;        // reset tree state, seed vertex 0
    logic scan_start;  // begin a pick scan
    logic scan_step;   // read the best link of vertex scan_v for the pick scan
    logic commit_pick; // mark the picked vertex in tree
    logic relax_rd;    // issue matrix and best-link reads for vertex scan_v
    logic relax_wr;    // apply the read result to the previous vertex
    logic fin_step;    // read vertex scan_v to fold it into the bottleneck
    logic clr_step;    // clear the pair memory entry at clr_addr
    logic [VW-1:0] scan_v;
    logic [AW-1:0] clr_addr;
  } mstb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic found;
    logic disc;
  } mstb_sts_t;

endpackage

// ===== hw/rtl/mstb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstb_edge_if / mstb_result_if
// Valid/ready channels for edge words and result words.
// ----------------------------------------------------------------------------
interface mstb_edge_if;
  logic              valid;
  logic              ready;
  logic [5:0]        from_vertex;
  logic [5:0]        to_vertex;
  logic signed [31:0] edge_weight_in;
  logic              last_edge;
  modport source (output valid, from_vertex, to_vertex, edge_weight_in, last_edge,
                  input ready);
  modport sink   (input valid, from_vertex, to_vertex, edge_weight_in, last_edge,
                  output ready);
endinterface

interface mstb_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] bottleneck_weight;
  logic [1:0]         status;
  modport source (output valid, bottleneck_weight, status, input ready);
  modport sink   (input valid, bottleneck_weight, status, output ready);
endinterface

// ===== hw/rtl/mstb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstb_datapath
// Pair memory, best-link memory, per-vertex tree flags, pick and bottleneck
// registers.
// ----------------------------------------------------------------------------
module mstb_datapath import mstb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  mstb_cmd_t          cmd,
  input  logic [VW-1:0]      ld_a,
  input  logic [VW-1:0]      ld_b,
  input  logic signed [31:0] ld_w,
  output mstb_sts_t          sts,
  output logic signed [31:0] lightest
);

  // pair memory word: presence flag above the weight, registered read
  logic [32:0]        pmem [MAX_VERTICES*MAX_VERTICES];
  logic [32:0]        prd_r;
  logic signed [31:0] wrd;

  // best link per vertex, registered read
  logic signed [31:0] bmem [MAX_VERTICES];
  logic signed [31:0] brd_r;
  logic [VW-1:0]      sv_r;    // vertex whose reads are in flight

  logic [MAX_VERTICES-1:0] known_r, tree_r;

  logic [VW-1:0]      pick_r;
  logic               found_r;
  logic signed [31:0] pickw_r;
  logic               disc_r;
  logic signed [31:0] light_r;
  logic               any_r;
  logic               scan_p_r;
  logic               fin_p_r;

  logic [VW-1:0] wa, wb;
  logic [AW-1:0] waddr, raddr, maddr;
  logic [32:0]   mdata;
  logic          wr_en;
  logic          mem_we;
  logic          v_ok;
  logic          relax_upd;

  assign wa    = cmd.pass_a ? ld_a : ld_b;
  assign wb    = cmd.pass_a ? ld_b : ld_a;
  assign waddr = {wa, wb};
  assign raddr = cmd.relax_rd ? {pick_r, cmd.scan_v} : {ld_a, ld_b};
  assign wrd   = prd_r[31:0];
  // store when empty or heavier; the pair was read before the first write
  assign wr_en  = cmd.load && (!prd_r[32] || ld_w > wrd);
  assign mem_we = cmd.clr_step || wr_en;
  assign maddr  = cmd.clr_step ? cmd.clr_addr : waddr;
  assign mdata  = cmd.clr_step ? 33'd0 : {1'b1, ld_w};

  assign v_ok      = !tree_r[sv_r] && known_r[sv_r];
  assign relax_upd = cmd.relax_wr && !tree_r[sv_r] && prd_r[32] &&
                     (!known_r[sv_r] || wrd > brd_r);

  always_ff @(posedge clk) begin
    if (mem_we) pmem[maddr] <= mdata;
    prd_r <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) bmem[0] <= 32'sd0;
    else if (relax_upd) bmem[sv_r] <= wrd;
    brd_r <= bmem[cmd.scan_v];
    sv_r  <= cmd.scan_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r  <= '0;
      tree_r   <= '0;
      found_r  <= 1'b0;
      disc_r   <= 1'b0;
      any_r    <= 1'b0;
      scan_p_r <= 1'b0;
      fin_p_r  <= 1'b0;
    end else begin
      scan_p_r <= cmd.scan_step;
      fin_p_r  <= cmd.fin_step;
      if (cmd.init) begin
        known_r <= {{(MAX_VERTICES-1){1'b0}}, 1'b1};
        tree_r  <= '0;
        disc_r  <= 1'b0;
        any_r   <= 1'b0;
      end
      if (cmd.scan_start) found_r <= 1'b0;
      if (scan_p_r && v_ok && (!found_r || brd_r > pickw_r)) begin
        found_r <= 1'b1;
        pick_r  <= sv_r;
        pickw_r <= brd_r;
      end
      if (cmd.commit_pick) tree_r[pick_r] <= 1'b1;
      if (relax_upd) known_r[sv_r] <= 1'b1;
      if (fin_p_r) begin
        if (!tree_r[sv_r]) disc_r <= 1'b1;
        else if (!any_r || brd_r < light_r) begin
          light_r <= brd_r;
          any_r   <= 1'b1;
        end
      end
    end
  end

  assign sts.found = found_r;
  assign sts.disc  = disc_r;
  assign lightest  = light_r;

endmodule

// ===== hw/rtl/mstb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mstb_ctrl
// Sequencer for loading, Prim passes, bottleneck fold and matrix clear.
// ----------------------------------------------------------------------------
module mstb_ctrl import mstb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_last,
  input  logic [CW-1:0] count,
  input  mstb_sts_t     sts,
  output mstb_cmd_t     cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic          out_zero
);

  typedef enum logic [10:0] {
    S_WIPE  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LDR   = 11'b00000000100,
    S_LDA   = 11'b00000001000,
    S_LDB   = 11'b00000010000,
    S_INIT  = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_RELAX = 11'b00010000000,
    S_FIN   = 11'b00100000000,
    S_CLR   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t        st_r, st_nxt;
  logic [VW:0]   v_r, v_nxt;
  logic [AW-1:0] c_r, c_nxt;
  logic [VW:0]   n_r;
  logic          last_r;
  logic [1:0]    stat_r, stat_nxt;
  logic [VW:0]   n_live;

  always_comb begin
    if (count > CW'(MAX_VERTICES)) n_live = (VW+1)'(MAX_VERTICES);
    else if (count == '0)         n_live = (VW+1)'(1);
    else                           n_live = count[VW:0];
  end

  assign in_ready   = (st_r == S_IDLE);
  assign out_valid  = (st_r == S_OUT);
  assign out_status = stat_r;
  assign out_zero   = (stat_r != ST_FOUND);

  always_comb begin
    st_nxt   = st_r;
    v_nxt    = v_r;
    c_nxt    = c_r;
    stat_nxt = stat_r;
    cmd      = '0;
    cmd.scan_v   = v_r[VW-1:0];
    cmd.clr_addr = c_r;
    case (st_r)
      S_WIPE: begin
        cmd.clr_step = 1'b1;
        c_nxt = c_r + 1'b1;
        if (c_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) st_nxt = S_LDR;
      // read the stored pair before either write
      S_LDR: st_nxt = S_LDA;
      S_LDA: begin
        cmd.pass_a = 1'b1;
        cmd.load   = 1'b1;
        st_nxt     = S_LDB;
      end
      S_LDB: begin
        cmd.load = 1'b1;
        if (!last_r) st_nxt = S_IDLE;
        else if (n_r == (VW+1)'(1)) begin
          stat_nxt = ST_SINGLE;
          c_nxt    = '0;
          st_nxt   = S_CLR;
        end else st_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init       = 1'b1;
        cmd.scan_start = 1'b1;
        v_nxt          = '0;
        st_nxt         = S_SCAN;
      end
      S_SCAN: begin
        if (v_r < n_r) begin
          cmd.scan_step = 1'b1;
          v_nxt = v_r + 1'b1;
        end else if (v_r == n_r) begin
          // let the last compare land
          v_nxt = v_r + 1'b1;
        end else if (sts.found) begin
          cmd.commit_pick = 1'b1;
          v_nxt  = '0;
          st_nxt = S_RELAX;
        end else begin
          v_nxt  = (VW+1)'(1);
          st_nxt = S_FIN;
        end
      end
      S_RELAX: begin
        // read address v, apply the result for v-1 in the next cycle
        cmd.relax_wr = (v_r != '0);
        if (v_r < n_r) begin
          cmd.relax_rd = 1'b1;
          v_nxt = v_r + 1'b1;
        end else begin
          cmd.scan_start = 1'b1;
          v_nxt  = '0;
          st_nxt = S_SCAN;
        end
      end
      S_FIN: begin
        if (v_r < n_r) begin
          cmd.fin_step = 1'b1;
          v_nxt = v_r + 1'b1;
        end else if (v_r == n_r) begin
          v_nxt = v_r + 1'b1;
        end else begin
          stat_nxt = sts.disc ? ST_DISCONNECTED : ST_FOUND;
          c_nxt    = '0;
          st_nxt   = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        c_nxt = c_r + 1'b1;
        if (c_r == '1) st_nxt = S_OUT;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_WIPE;
      v_r    <= '0;
      c_r    <= '0;
      stat_r <= ST_FOUND;
    end else begin
      st_r   <= st_nxt;
      v_r    <= v_nxt;
      c_r    <= c_nxt;
      stat_r <= stat_nxt;
    end
    if (st_r == S_IDLE && in_valid) begin
      last_r <= in_last;
      n_r    <= n_live;
    end
  end

endmodule

// ===== hw/rtl/max_spanning_tree_bottleneck.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_spanning_tree_bottleneck
// Loads a graph edge by edge, then runs Prim for a maximum spanning tree and
// reports its lightest edge.
//
//   channel | dir | contents
//   in_     | in  | from_vertex, to_vertex, edge_weight_in, last_edge
//   out_    | out | bottleneck_weight, status
//   cfg_    | in  | vertex_count write
//
// An edge word is handled as accept, read of the stored pair and two symmetric
// writes that keep the heavier weight. A last word then runs Prim, with a pick
// scan and a relax pass per picked vertex over one memory port, then a fold of
// the tree into the bottleneck and a clear of all 4096 pair memory entries, then
// waits on out_ready. A single-vertex graph goes straight to the clear.
// After reset the same clear runs before the first word is taken.
// ----------------------------------------------------------------------------
module max_spanning_tree_bottleneck import mstb_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mstb_edge_if.sink     in_ch,
  mstb_result_if.source out_ch,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata
);

  logic [CW-1:0]      count_r;
  logic [VW-1:0]      a_r, b_r;
  logic signed [31:0] w_r;
  logic               ok_r;
  logic [VW:0]        n_chk;
  mstb_cmd_t          cmd, cmd_g;
  mstb_sts_t          sts;
  logic signed [31:0] lightest;
  logic               zero;
  logic               acc;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= CW'(MAX_VERTICES);
    else if (cfg_we) count_r <= cfg_wdata;
  end

  always_comb begin
    if (count_r > CW'(MAX_VERTICES)) n_chk = (VW+1)'(MAX_VERTICES);
    else if (count_r == '0)         n_chk = (VW+1)'(1);
    else                             n_chk = count_r[VW:0];
  end

  assign acc = in_ch.valid && in_ch.ready;

  // hold the accepted word; drop it if out of range or too light
  always_ff @(posedge clk) begin
    if (acc) begin
      a_r  <= in_ch.from_vertex;
      b_r  <= in_ch.to_vertex;
      w_r  <= in_ch.edge_weight_in;
      ok_r <= ({1'b0, in_ch.from_vertex} < n_chk) && ({1'b0, in_ch.to_vertex} < n_chk)
              && (in_ch.edge_weight_in >= WEIGHT_FLOOR);
    end
  end

  always_comb begin
    cmd_g      = cmd;
    cmd_g.load = cmd.load && ok_r;
  end

  mstb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last_edge),
    .count     (count_r),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_status(out_ch.status),
    .out_zero  (zero)
  );

  mstb_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd_g),
    .ld_a    (a_r),
    .ld_b    (b_r),
    .ld_w    (w_r),
    .sts     (sts),
    .lightest(lightest)
  );

  assign out_ch.bottleneck_weight = zero ? 32'sd0 : lightest;

endmodule
